// ===== src/rtdd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtdd_pkg
// Shared types and constants for the RFID tag de-duplication table.
// ----------------------------------------------------------------------------
package rtdd_pkg;

	// outcome codes of one result transaction
	typedef enum logic [1:0] {
		OUT_NEW_TAG   = 2'd0,
		OUT_DUPLICATE = 2'd1,
		OUT_BAD_LEN   = 2'd2,
		OUT_ZERO_PFX  = 2'd3
	} outcome_t;

	// accepted EPC lengths in bytes
	localparam logic [7:0] LEN_MIN = 8'd11;
	localparam logic [7:0] LEN_MAX = 8'd14;

	localparam int EPC_UPPER_W = 48;
	localparam int EPC_LOWER_W = 64;
	localparam int EPC_LEN_W   = 4;
	localparam int ENTRY_W     = EPC_LEN_W + EPC_UPPER_W + EPC_LOWER_W;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [EPC_LEN_W-1:0]   len;
		logic [EPC_UPPER_W-1:0] upper;
		logic [EPC_LOWER_W-1:0] lower;
	} entry_t;

	// one result item, packed into m_tdata from the lowest bit up
	typedef struct packed {
		logic [2:0] record_number;
		logic [3:0] entries_held;
		logic [2:0] slot;
		outcome_t   outcome;
	} result_t;

	localparam int RESULT_W = 12;
	localparam int M_DATA_W = 16;

endpackage

// ===== src/rfid_tag_dedup_table.sv =====
// ----------------------------------------------------------------------------
// rfid_tag_dedup_table
// Parses RFID inventory reply bytes into EPC records and keeps a round-robin
// table of unique EPCs, reporting one result per record.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                         handshake
//  s_*      in   tdata[7:0] data_byte, tuser reply_start         tvalid/tready
//  m_*      out  tdata[1:0] outcome, [4:2] slot,                 tvalid/tready
//                [8:5] entries_held, [11:9] record_number
//
//  Header, length and EPC bytes are accepted while s_tready is high. The final
//  EPC byte starts a search that reads one table entry per cycle through the
//  single memory read port and one comparator, ending early on a match.
//  s_tready is low during the search.
//  A two-entry output stage (register plus skid) lets input continue while a
//  result waits; the output stage stalls input only when both hold a result.
//  arst_n clears all control state; the table memory has no reset and only
//  entries below the held count are ever compared.
//
module rfid_tag_dedup_table #(
	parameter int TABLE_DEPTH = 8,
	parameter int MAX_RECORDS = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: tdata = data_byte[7:0]; tuser = reply_start
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	// master stream: tdata = outcome[1:0], slot[4:2], entries_held[8:5],
	// record_number[11:9], zeros[15:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);
	import rtdd_pkg::*;

	localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int HW  = $clog2(TABLE_DEPTH + 1);
	localparam int RLW = $clog2(MAX_RECORDS + 1);
	localparam logic [7:0]     MAX_REC_B  = 8'(MAX_RECORDS);
	localparam logic [AW-1:0]  LAST_SLOT  = AW'(TABLE_DEPTH - 1);
	localparam logic [HW-1:0]  DEPTH_CNT  = HW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LENGTH,
		PH_EPC,
		PH_SKIP,
		PH_SEARCH
	} phase_t;

	phase_t                 phase_q;
	logic [RLW-1:0]         records_left_q;
	logic [2:0]             rec_idx_q;
	logic [7:0]             rec_len_q;
	logic [7:0]             bytes_left_q;
	logic [EPC_UPPER_W-1:0] asm_upper_q;
	logic [EPC_LOWER_W-1:0] asm_lower_q;
	logic [HW-1:0]          held_q;
	logic [AW-1:0]          next_slot_q;
	logic [HW-1:0]          issue_idx_q;

	entry_t                 mem_q [TABLE_DEPTH];
	entry_t                 rd_entry_s1;
	logic                   cmp_vld_s1;
	logic                   cmp_last_s1;

	logic                   out_v_q;
	result_t                out_q;
	logic                   skid_v_q;
	result_t                skid_q;

	logic                   in_acc;
	logic                   byte_acc;
	logic [7:0]             b;
	logic                   len_ok;
	logic                   zp_hit;
	logic                   issuing;
	logic                   cmp_match;
	logic                   dup;
	logic                   ins;
	logic                   finish;
	logic                   rec_done;
	logic [HW-1:0]          held_inc;
	logic [RLW-1:0]         rl_dec;
	logic [RLW-1:0]         rl_start;
	logic                   res_valid;
	result_t                res;
	logic                   pop;
	entry_t                 wr_entry;

	// input handshake and byte decode
	assign s_tready = (phase_q != PH_SEARCH) && !skid_v_q;
	assign in_acc   = s_tvalid && s_tready;
	assign byte_acc = in_acc && !s_tuser;
	assign b        = s_tdata;
	assign len_ok   = (b >= LEN_MIN) && (b <= LEN_MAX);
	assign rl_start = (b > MAX_REC_B) ? RLW'(MAX_RECORDS) : RLW'(b);

	// second EPC byte with both leading bytes zero
	assign zp_hit = (phase_q == PH_EPC) &&
		((9'(bytes_left_q) + 9'd1) == 9'(rec_len_q)) &&
		({asm_lower_q[7:0], b} == 16'h0000);

	// search: one read issued per cycle, compared in the next cycle from the registered read data
	assign issuing   = (phase_q == PH_SEARCH) && (issue_idx_q < held_q);
	assign cmp_match = (rd_entry_s1.len == rec_len_q[EPC_LEN_W-1:0]) &&
		(rd_entry_s1.upper == asm_upper_q) && (rd_entry_s1.lower == asm_lower_q);
	assign dup       = cmp_vld_s1 && cmp_match;
	assign ins       = ((phase_q == PH_SEARCH) && (held_q == '0)) ||
		(cmp_vld_s1 && !cmp_match && cmp_last_s1);
	assign finish    = dup || ins;
	assign held_inc  = (held_q < DEPTH_CNT) ? held_q + 1'b1 : held_q;

	// end of a record, from the length byte, the skip phase or the search
	assign rec_done = (byte_acc && (phase_q == PH_LENGTH) && (b == 8'd0)) ||
		(byte_acc && (phase_q == PH_SKIP) && (bytes_left_q <= 8'd1)) ||
		finish;
	assign rl_dec   = (records_left_q != '0) ? records_left_q - 1'b1 : records_left_q;

	// result of this cycle
	always_comb begin
		res_valid         = 1'b0;
		res.outcome       = OUT_NEW_TAG;
		res.slot          = 3'd0;
		res.entries_held  = 4'(held_q);
		res.record_number = rec_idx_q;
		if (byte_acc && (phase_q == PH_LENGTH) && !len_ok) begin
			res_valid   = 1'b1;
			res.outcome = OUT_BAD_LEN;
		end else if (byte_acc && zp_hit) begin
			res_valid   = 1'b1;
			res.outcome = OUT_ZERO_PFX;
		end else if (dup) begin
			res_valid   = 1'b1;
			res.outcome = OUT_DUPLICATE;
		end else if (ins) begin
			res_valid        = 1'b1;
			res.outcome      = OUT_NEW_TAG;
			res.slot         = 3'(next_slot_q);
			res.entries_held = 4'(held_inc);
		end
	end

	// parser and table control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			records_left_q <= '0;
			rec_idx_q      <= '0;
			rec_len_q      <= '0;
			bytes_left_q   <= '0;
			asm_upper_q    <= '0;
			asm_lower_q    <= '0;
			held_q         <= '0;
			next_slot_q    <= '0;
			issue_idx_q    <= '0;
			cmp_vld_s1     <= 1'b0;
			cmp_last_s1    <= 1'b0;
		end else begin
			cmp_vld_s1  <= issuing && !finish;
			cmp_last_s1 <= (issue_idx_q == held_q - 1'b1);
			if (issuing && !finish) begin
				issue_idx_q <= issue_idx_q + 1'b1;
			end
			if (ins) begin
				next_slot_q <= (next_slot_q == LAST_SLOT) ? '0 : next_slot_q + 1'b1;
				held_q      <= held_inc;
			end

			if (in_acc && s_tuser) begin
				// reply start: tag count, abandons any reply in progress
				records_left_q <= rl_start;
				rec_idx_q      <= '0;
				phase_q        <= (rl_start == '0) ? PH_IDLE : PH_LENGTH;
			end else if (rec_done) begin
				records_left_q <= rl_dec;
				rec_idx_q      <= rec_idx_q + 3'd1;
				phase_q        <= (rl_dec == '0) ? PH_IDLE : PH_LENGTH;
				if (phase_q == PH_LENGTH) begin
					rec_len_q    <= b;
					bytes_left_q <= b;
				end else if (phase_q == PH_SKIP) begin
					bytes_left_q <= '0;
				end
			end else if (byte_acc) begin
				case (phase_q)
					PH_LENGTH: begin
						rec_len_q    <= b;
						bytes_left_q <= b;
						if (len_ok) begin
							asm_upper_q <= '0;
							asm_lower_q <= '0;
							phase_q     <= PH_EPC;
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					PH_SKIP: begin
						bytes_left_q <= bytes_left_q - 8'd1;
					end
					PH_EPC: begin
						asm_upper_q  <= {asm_upper_q[EPC_UPPER_W-9:0],
							asm_lower_q[EPC_LOWER_W-1 -: 8]};
						asm_lower_q  <= {asm_lower_q[EPC_LOWER_W-9:0], b};
						bytes_left_q <= bytes_left_q - 8'd1;
						if (zp_hit) begin
							phase_q        <= PH_IDLE;
							records_left_q <= '0;
						end else if (bytes_left_q == 8'd1) begin
							issue_idx_q <= '0;
							phase_q     <= PH_SEARCH;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// table memory: one write port, one registered read port
	assign wr_entry.len   = rec_len_q[EPC_LEN_W-1:0];
	assign wr_entry.upper = asm_upper_q;
	assign wr_entry.lower = asm_lower_q;

	always_ff @(posedge clk) begin
		if (ins) begin
			mem_q[next_slot_q] <= wr_entry;
		end
		rd_entry_s1 <= mem_q[issue_idx_q[AW-1:0]];
	end

	// output register with skid stage
	assign pop      = out_v_q && m_tready;
	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(M_DATA_W - RESULT_W){1'b0}}, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q) begin
			out_v_q <= res_valid;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= res_valid;
			end else begin
				out_v_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (res_valid) begin
					skid_q <= res;
				end
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	// checks
	a_dup_ins_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(dup && ins))
		else $error("duplicate and insert in the same cycle");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH_CNT)
		else $error("held count above table depth");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while output register is empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_v_q && !m_tready) |-> !skid_v_q)
		else $error("result pushed into a full output stage");

	a_insert_held: assert property (@(posedge clk) disable iff (!arst_n)
		ins |=> (held_q != '0) && (phase_q != PH_SEARCH))
		else $error("insert did not update held count or end the search");

endmodule
